[design/etr_pkg.sv]
// ----------------------------------------------------------------------------
// etr_pkg: event timer register block shared definitions
// Word types, register indexes, operation codes and timer control layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etr_pkg;

  // number of comparator timers
  localparam int NUM_TIMERS = 3;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // quadword register indexes
  localparam logic [6:0] ADDR_CAPS    = 7'd0;
  localparam logic [6:0] ADDR_GCONF   = 7'd2;
  localparam logic [6:0] ADDR_STATUS  = 7'd4;
  localparam logic [6:0] ADDR_COUNTER = 7'h1E;
  localparam logic [6:0] ADDR_TIMER0  = 7'd32;

  // register within a timer slot
  localparam logic [1:0] SUB_CFG = 2'd0;
  localparam logic [1:0] SUB_CMP = 2'd1;

  // capabilities revision
  localparam logic [7:0] CAPS_REVISION = 8'h01;

  // configuration port register indexes and reset values
  localparam logic [0:0]  CFG_TICK_PERIOD   = 1'b0;
  localparam logic [0:0]  CFG_ROUTE_CAP     = 1'b1;
  localparam logic [26:0] TICK_PERIOD_RESET = 27'd69841279;
  localparam logic [31:0] ROUTE_CAP_RESET   = 32'd15728640;

  // request word
  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  address;
    logic [63:0] write_data;
  } etr_in_t;

  // response word
  typedef struct packed {
    logic [63:0]           read_data;
    logic [NUM_TIMERS-1:0] irq_lines;
    logic [NUM_TIMERS-1:0] status_bits;
  } etr_out_t;

  // stored timer control
  typedef struct packed {
    logic [4:0] route;
    logic       valset;
    logic       periodic;
    logic       int_enable;
    logic       level;
  } etr_tctl_t;

  // commands from the decoder to one timer
  typedef struct packed {
    logic cfg_wr;
    logic cmp_wr;
    logic tick;
  } etr_tcmd_t;

  // per-timer results for this word
  typedef struct packed {
    logic set_status;
    logic pulse;
    logic line_ok;
  } etr_tstat_t;

endpackage

[design/event_timer_registers.sv]
// ----------------------------------------------------------------------------
// event_timer_registers: high precision event timer register block
// 64-bit register file with main counter, interrupt status and comparator
// timers; request words read, write or advance the counter by one tick.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              content
// req       in         req_valid / req_ready  operation, address, write_data
// rsp       out        rsp_valid / rsp_ready  read_data, irq_lines, status_bits
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// one word per clock while req_ready is high; each word is decoded and applied in the cycle it is
// accepted and its response appears in the output register on the next cycle.
// the longest path is the 64-bit counter increment and comparator compare.
// req_ready drops only while a response is held and rsp_ready is low.
// synchronous reset sets all state but the response word to its documented values.
//
`timescale 1ns / 1ps

module event_timer_registers
  import etr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  etr_in_t     req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output etr_out_t    rsp,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [26:0]           tick_period_fs;
  logic [31:0]           route_capability;
  logic [63:0]           main_counter;
  logic [63:0]           main_counter_next;
  logic [63:0]           counter_inc;
  logic [1:0]            general_enable;
  logic [1:0]            general_enable_next;
  logic [NUM_TIMERS-1:0] pending_status;
  logic [NUM_TIMERS-1:0] pending_status_next;

  logic        fire;
  logic        wr;
  logic        tick;
  logic        timer_space;
  logic [6:0]  toff;
  logic [4:0]  tslot;
  logic [1:0]  tsub;
  logic [63:0] caps_word;
  logic [63:0] timer_rdata;
  logic [63:0] read_data;
  logic [NUM_TIMERS-1:0] lines;

  etr_tcmd_t   tcmd [NUM_TIMERS];
  etr_tstat_t  tstat [NUM_TIMERS];
  logic [63:0] tcfg [NUM_TIMERS];
  logic [63:0] tcmp [NUM_TIMERS];

  // handshake
  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;
  assign wr        = fire && (req.operation == OP_WRITE);
  assign tick      = fire && (req.operation == OP_TICK) && general_enable[0];

  // timer slot decode
  assign timer_space = req.address >= ADDR_TIMER0;
  assign toff        = req.address - ADDR_TIMER0;
  assign tslot       = toff[6:2];
  assign tsub        = toff[1:0];

  assign counter_inc = main_counter + 64'd1;

  // timers
  for (genvar n = 0; n < NUM_TIMERS; n++) begin : g_timer
    assign tcmd[n].cfg_wr = wr && timer_space && (tslot == 5'(n)) && (tsub == SUB_CFG);
    assign tcmd[n].cmp_wr = wr && timer_space && (tslot == 5'(n)) && (tsub == SUB_CMP);
    assign tcmd[n].tick   = tick;

    etr_timer u_timer (
      .clk         (clk),
      .rst         (rst),
      .cmd         (tcmd[n]),
      .wdata       (req.write_data),
      .counter_inc (counter_inc),
      .route_mask  (route_capability),
      .cfg_word    (tcfg[n]),
      .comparator  (tcmp[n]),
      .stat        (tstat[n])
    );
  end

  // global register next state
  always_comb begin
    main_counter_next   = main_counter;
    general_enable_next = general_enable;
    pending_status_next = pending_status;
    if (wr && (req.address == ADDR_COUNTER)) begin
      main_counter_next = req.write_data;
    end else if (tick) begin
      main_counter_next = counter_inc;
    end
    if (wr && (req.address == ADDR_GCONF)) begin
      general_enable_next = req.write_data[1:0];
    end
    if (wr && (req.address == ADDR_STATUS)) begin
      pending_status_next = pending_status & ~req.write_data[NUM_TIMERS-1:0];
    end
    for (int n = 0; n < NUM_TIMERS; n++) begin
      if (tstat[n].set_status) begin
        pending_status_next[n] = 1'b1;
      end
    end
  end

  // interrupt lines after this word
  always_comb begin
    for (int n = 0; n < NUM_TIMERS; n++) begin
      lines[n] = tstat[n].pulse ||
                 (general_enable_next[0] && tstat[n].line_ok && pending_status_next[n]);
    end
  end

  // register read mux
  assign caps_word = {5'd0, tick_period_fs, 18'd0, 1'b1, 5'(NUM_TIMERS - 1), CAPS_REVISION};

  always_comb begin
    timer_rdata = '0;
    for (int n = 0; n < NUM_TIMERS; n++) begin
      if (timer_space && (tslot == 5'(n))) begin
        if (tsub == SUB_CFG) begin
          timer_rdata = tcfg[n];
        end else if (tsub == SUB_CMP) begin
          timer_rdata = tcmp[n];
        end
      end
    end
  end

  always_comb begin
    read_data = '0;
    if (req.operation == OP_READ) begin
      case (req.address)
        ADDR_CAPS:    read_data = caps_word;
        ADDR_GCONF:   read_data = 64'(general_enable);
        ADDR_STATUS:  read_data = 64'(pending_status);
        ADDR_COUNTER: read_data = main_counter;
        default:      read_data = timer_rdata;
      endcase
    end
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      main_counter   <= '0;
      general_enable <= '0;
      pending_status <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (fire) begin
        main_counter   <= main_counter_next;
        general_enable <= general_enable_next;
        pending_status <= pending_status_next;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response word
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.read_data   <= read_data;
      rsp.irq_lines   <= lines;
      rsp.status_bits <= pending_status_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_fs   <= TICK_PERIOD_RESET;
      route_capability <= ROUTE_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_PERIOD: tick_period_fs   <= cfg_data[26:0];
        CFG_ROUTE_CAP:   route_capability <= cfg_data;
        default:         ;
      endcase
    end
  end

  // non-read words return zero data
  assert property (@(posedge clk) disable iff (rst)
    (fire && (req.operation != OP_READ)) |=> (rsp.read_data == 64'd0))
    else $error("nonzero read data for a non-read word");

  // held response status matches live status
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status_bits == pending_status))
    else $error("response status differs from pending status");

  // enabled tick advances the counter by one
  assert property (@(posedge clk) disable iff (rst)
    (fire && (req.operation == OP_TICK) && general_enable[0])
      |=> (main_counter == $past(main_counter) + 64'd1))
    else $error("counter did not advance on enabled tick");

  // reads leave the counter alone
  assert property (@(posedge clk) disable iff (rst)
    (fire && (req.operation == OP_READ)) |=> $stable(main_counter))
    else $error("counter changed on a read");

endmodule

[design/etr_timer.sv]
// ----------------------------------------------------------------------------
// etr_timer: one comparator timer
// Holds the timer control, comparator and periodic interval, decodes config
// and comparator writes, and checks for a match on each advancing tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etr_timer
  import etr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  etr_tcmd_t   cmd,
  input  logic [63:0] wdata,
  input  logic [63:0] counter_inc,
  input  logic [31:0] route_mask,
  output logic [63:0] cfg_word,
  output logic [63:0] comparator,
  output etr_tstat_t  stat
);

  etr_tctl_t   ctl;
  etr_tctl_t   ctl_next;
  logic [63:0] cmp_next;
  logic [63:0] interval;
  logic [63:0] interval_next;
  logic [63:0] cmp_sum;
  logic        match;

  // periodic advance and match against the incremented counter
  assign cmp_sum = comparator + interval;
  assign match   = cmd.tick && (counter_inc == comparator);

  // next state
  always_comb begin
    ctl_next      = ctl;
    cmp_next      = comparator;
    interval_next = interval;
    if (cmd.cfg_wr) begin
      ctl_next.level      = wdata[1];
      ctl_next.int_enable = wdata[2];
      ctl_next.periodic   = wdata[3];
      ctl_next.valset     = wdata[6];
      ctl_next.route      = wdata[13:9];
    end
    if (cmd.cmp_wr) begin
      if (!ctl.periodic || ctl.valset) begin
        cmp_next = wdata;
      end
      if (ctl.periodic) begin
        interval_next = wdata;
      end
      ctl_next.valset = 1'b0;
    end
    if (match && ctl.periodic) begin
      cmp_next = cmp_sum;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= '0;
      comparator <= '1;
      interval   <= '0;
    end else begin
      ctl        <= ctl_next;
      comparator <= cmp_next;
      interval   <= interval_next;
    end
  end

  // match outcome and level line qualifier
  assign stat.set_status = match && ctl.int_enable && ctl.level;
  assign stat.pulse      = match && ctl.int_enable && !ctl.level;
  assign stat.line_ok    = ctl_next.level && ctl_next.int_enable;

  // config register read view
  assign cfg_word = {route_mask, 18'd0, ctl.route, 2'b00, ctl.valset, 1'b1, 1'b1,
                     ctl.periodic, ctl.int_enable, ctl.level, 1'b0};

endmodule
